// ===== sv/cascaded_pi_joint_regulator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded PI joint regulator
// Clocked on clk; the first form is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CASCADED_PI_JOINT_REGULATOR_TOP_MACROS_SVH
`define CASCADED_PI_JOINT_REGULATOR_TOP_MACROS_SVH

// Check outside reset
`define CPJR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included
`define CPJR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cpjr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpjr_pkg
// Widths, reset values, command types and saturation helper of the regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpjr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ERR_W     = DATA_W + 1;          // full-width differences
  localparam int GAIN_W    = DATA_W - 1;          // unsigned gains
  localparam int DT_W      = FRAC_BITS;           // time step, pure fraction
  localparam int FB_W      = 16;                  // drive feedback gain
  localparam int MODE_W    = 2;
  localparam int IDX_W     = 3;
  localparam int PROD_W    = ERR_W + GAIN_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;  // scaled product, signed
  localparam int ACC_W     = TERM_W + 2;          // room for a sum of three terms

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PKP  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PKI  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SKP  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SKI  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FB   = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOME = 3'd5;
  localparam logic [IDX_W-1:0] REG_MODE = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0] PKP_RESET  = GAIN_W'(1747627);
  localparam logic [GAIN_W-1:0] PKI_RESET  = GAIN_W'(2912711);
  localparam logic [GAIN_W-1:0] SKP_RESET  = GAIN_W'(29491200);
  localparam logic [GAIN_W-1:0] SKI_RESET  = GAIN_W'(655360000);
  localparam logic [FB_W-1:0]   FB_RESET   = FB_W'(66);
  localparam logic [DATA_W-1:0] HOME_RESET = '0;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(3);

  // Speed goal after reset: 0.2
  localparam logic [DATA_W-1:0] SG_RESET = DATA_W'(((2 ** (FRAC_BITS + 1)) + 5) / 10);

  localparam logic signed [ACC_W-1:0] DATA_MAX =
    {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DATA_MIN =
    {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TP_MUL,
    ST_TP_WR,
    ST_PERR,
    ST_PES_MUL,
    ST_PES_WR,
    ST_G_PI,
    ST_G_FB,
    ST_G_SUM,
    ST_SERR,
    ST_SES_MUL,
    ST_SES_WR,
    ST_D_I,
    ST_D_SUM
  } cpjr_state_t;

  typedef enum logic [2:0] {
    A_VSET,
    A_ERR,
    A_PES,
    A_LD,
    A_SES
  } cpjr_asel_t;

  typedef enum logic [2:0] {
    B_DT,
    B_PKP,
    B_PKI,
    B_FB,
    B_SKP,
    B_SKI
  } cpjr_bsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } cpjr_accop_t;

  typedef enum logic [1:0] {
    ERR_HOLD,
    ERR_POS,
    ERR_SPD
  } cpjr_errop_t;

  typedef struct packed {
    logic        take_in;
    logic        mul_en;
    cpjr_asel_t  a_sel;
    cpjr_bsel_t  b_sel;
    cpjr_errop_t err_op;
    cpjr_accop_t acc_op;
    logic        wr_tp;
    logic        wr_pes;
    logic        wr_sg;
    logic        wr_ses;
    logic        wr_drv;
  } cpjr_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
  } cpjr_stat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } cpjr_clip_t;

  function automatic cpjr_clip_t clip_data(input logic signed [ACC_W-1:0] v);
    cpjr_clip_t r;
    if (v > DATA_MAX) begin
      r.val  = DATA_MAX[DATA_W-1:0];
      r.clip = 1'b1;
    end else if (v < DATA_MIN) begin
      r.val  = DATA_MIN[DATA_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[DATA_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cpjr_if.sv =====
// ----------------------------------------------------------------------------
// cpjr_if
// Valid/ready channels for the regulator's tick items and drive results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpjr_in_if
  import cpjr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measured_position;
  logic signed [DATA_W-1:0] measured_speed;
  logic signed [DATA_W-1:0] velocity_setpoint;
  logic        [DT_W-1:0]   time_step;

  modport source (
    output valid, measured_position, measured_speed, velocity_setpoint, time_step,
    input  ready
  );
  modport sink (
    input  valid, measured_position, measured_speed, velocity_setpoint, time_step,
    output ready
  );
endinterface

interface cpjr_out_if
  import cpjr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive_force;
  logic                     saturated;

  modport source (
    output valid, drive_force, saturated,
    input  ready
  );
  modport sink (
    input  valid, drive_force, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/cpjr_datapath.sv =====
// ----------------------------------------------------------------------------
// cpjr_datapath
// Gain registers, loop state, one shared multiplier and a sum register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpjr_datapath
  import cpjr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [IDX_W-1:0]         cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_wdata,
  input  wire logic signed [DATA_W-1:0] measured_position,
  input  wire logic signed [DATA_W-1:0] measured_speed,
  input  wire logic signed [DATA_W-1:0] velocity_setpoint,
  input  wire logic [DT_W-1:0]          time_step,
  input  wire cpjr_cmd_t                cmd,
  output cpjr_stat_t                    stat,
  output logic signed [DATA_W-1:0]      drive_force,
  output logic                          saturated
);

  logic [GAIN_W-1:0]        pkp_r, pki_r, skp_r, ski_r;
  logic [FB_W-1:0]          fb_r;
  logic [MODE_W-1:0]        mode_r;

  logic signed [DATA_W-1:0] tp_r, pes_r, sg_r, ses_r, ld_r;
  logic signed [DATA_W-1:0] pos_r, spd_r, vset_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic                     neg_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [DATA_W-1:0] drv_out_r;
  logic                     sat_out_r;

  logic signed [ERR_W-1:0]  a_val;
  logic [ERR_W-1:0]         a_mag;
  logic [GAIN_W-1:0]        b_val;
  logic [PROD_W-1:0]        prod_shr;
  logic [TERM_W-1:0]        term_mag;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext;
  cpjr_clip_t               tp_c, pes_c, sg_c, ses_c, drv_c;

  // Configuration; home position only matters at reset, where it is the
  // reset value, so a write to it has nothing to update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkp_r  <= PKP_RESET;
      pki_r  <= PKI_RESET;
      skp_r  <= SKP_RESET;
      ski_r  <= SKI_RESET;
      fb_r   <= FB_RESET;
      mode_r <= MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PKP:  pkp_r  <= cfg_wdata[GAIN_W-1:0];
        REG_PKI:  pki_r  <= cfg_wdata[GAIN_W-1:0];
        REG_SKP:  skp_r  <= cfg_wdata[GAIN_W-1:0];
        REG_SKI:  ski_r  <= cfg_wdata[GAIN_W-1:0];
        REG_FB:   fb_r   <= cfg_wdata[FB_W-1:0];
        REG_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        REG_HOME: ;
        default:  ;
      endcase
    end
  end

  assign stat.mode = mode_r;

  // Multiplier operands: sign and magnitude
  always_comb begin
    unique case (cmd.a_sel)
      A_VSET:  a_val = {vset_r[DATA_W-1], vset_r};
      A_ERR:   a_val = err_r;
      A_PES:   a_val = {pes_r[DATA_W-1], pes_r};
      A_LD:    a_val = {ld_r[DATA_W-1], ld_r};
      A_SES:   a_val = {ses_r[DATA_W-1], ses_r};
      default: a_val = err_r;
    endcase
    unique case (cmd.b_sel)
      B_DT:    b_val = {{(GAIN_W - DT_W){1'b0}}, dt_r};
      B_PKP:   b_val = pkp_r;
      B_PKI:   b_val = pki_r;
      B_FB:    b_val = {{(GAIN_W - FB_W){1'b0}}, fb_r};
      B_SKP:   b_val = skp_r;
      B_SKI:   b_val = ski_r;
      default: b_val = {{(GAIN_W - DT_W){1'b0}}, dt_r};
    endcase
    a_mag    = a_val[ERR_W-1] ? (~a_val + 1'b1) : a_val;
    prod_nxt = PROD_W'(a_mag) * PROD_W'(b_val);
  end

  // Scaled product, truncated toward zero; magnitude stays below 2^(TERM_W-1)
  always_comb begin
    prod_shr = prod_r >> FRAC_BITS;
    term_mag = prod_shr[TERM_W-1:0];
    term     = neg_r ? -$signed(term_mag) : $signed(term_mag);
    term_ext = {{(ACC_W - TERM_W){term[TERM_W-1]}}, term};
  end

  always_comb begin
    unique case (cmd.acc_op)
      ACC_HOLD: acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = term_ext;
      ACC_ADD:  acc_nxt = acc_r + term_ext;
      ACC_SUB:  acc_nxt = acc_r - term_ext;
      default:  acc_nxt = acc_r;
    endcase
    unique case (cmd.err_op)
      ERR_HOLD: err_nxt = err_r;
      ERR_POS:  err_nxt = ERR_W'(tp_r) - ERR_W'(pos_r);
      ERR_SPD:  err_nxt = ERR_W'(sg_r) - ERR_W'(spd_r);
      default:  err_nxt = err_r;
    endcase
    tp_c  = clip_data(ACC_W'(tp_r) + term_ext);
    pes_c = clip_data(ACC_W'(pes_r) + term_ext);
    ses_c = clip_data(ACC_W'(ses_r) + term_ext);
    sg_c  = clip_data(acc_nxt);
    drv_c = clip_data(acc_nxt);
    sat_nxt = sat_r
            | (cmd.wr_tp  & tp_c.clip)
            | (cmd.wr_pes & pes_c.clip)
            | (cmd.wr_sg  & sg_c.clip)
            | (cmd.wr_ses & ses_c.clip)
            | (cmd.wr_drv & drv_c.clip);
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r  <= HOME_RESET;
      pes_r <= '0;
      sg_r  <= SG_RESET;
      ses_r <= '0;
      ld_r  <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.wr_tp)  tp_r  <= tp_c.val;
      if (cmd.wr_pes) pes_r <= pes_c.val;
      if (cmd.wr_sg)  sg_r  <= sg_c.val;
      if (cmd.wr_ses) ses_r <= ses_c.val;
      if (cmd.wr_drv) ld_r  <= drv_c.val;
      sat_r <= cmd.take_in ? 1'b0 : sat_nxt;
    end
  end

  // Item latch, work registers and result register
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      pos_r  <= measured_position;
      spd_r  <= measured_speed;
      vset_r <= velocity_setpoint;
      dt_r   <= time_step;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      neg_r  <= a_val[ERR_W-1];
    end
    err_r <= err_nxt;
    acc_r <= acc_nxt;
    if (cmd.wr_drv) begin
      drv_out_r <= drv_c.val;
      sat_out_r <= sat_nxt;
    end
  end

  assign drive_force = drv_out_r;
  assign saturated   = sat_out_r;

endmodule

`default_nettype wire

// ===== sv/cpjr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpjr_ctrl
// Tick sequencer: steps the shared multiplier through both loops.
// ----------------------------------------------------------------------------
`default_nettype none

module cpjr_ctrl
  import cpjr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire cpjr_stat_t stat,
  output cpjr_cmd_t       cmd
);

  cpjr_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.a_sel     = A_ERR;
    cmd.b_sel     = B_DT;
    cmd.err_op    = ERR_HOLD;
    cmd.acc_op    = ACC_HOLD;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
        if (in_valid) begin
          priority if (stat.mode[0]) state_nxt = ST_TP_MUL;
          else if (stat.mode[1])     state_nxt = ST_PERR;
          else                       state_nxt = ST_SERR;
        end
      end
      ST_TP_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = A_VSET;
        state_nxt  = ST_TP_WR;
      end
      ST_TP_WR: begin
        cmd.wr_tp = 1'b1;
        state_nxt = stat.mode[1] ? ST_PERR : ST_SERR;
      end
      ST_PERR: begin
        cmd.err_op = ERR_POS;
        state_nxt  = ST_PES_MUL;
      end
      ST_PES_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_PES_WR;
      end
      ST_PES_WR: begin
        // write the sum and start the proportional product together
        cmd.wr_pes = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.b_sel  = B_PKP;
        state_nxt  = ST_G_PI;
      end
      ST_G_PI: begin
        cmd.acc_op = ACC_LOAD;
        cmd.mul_en = 1'b1;
        cmd.a_sel  = A_PES;
        cmd.b_sel  = B_PKI;
        state_nxt  = ST_G_FB;
      end
      ST_G_FB: begin
        cmd.acc_op = ACC_ADD;
        cmd.mul_en = 1'b1;
        cmd.a_sel  = A_LD;
        cmd.b_sel  = B_FB;
        state_nxt  = ST_G_SUM;
      end
      ST_G_SUM: begin
        cmd.acc_op = ACC_SUB;
        cmd.wr_sg  = 1'b1;
        state_nxt  = ST_SERR;
      end
      ST_SERR: begin
        cmd.err_op = ERR_SPD;
        state_nxt  = ST_SES_MUL;
      end
      ST_SES_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SES_WR;
      end
      ST_SES_WR: begin
        cmd.wr_ses = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.b_sel  = B_SKP;
        state_nxt  = ST_D_I;
      end
      ST_D_I: begin
        cmd.acc_op = ACC_LOAD;
        cmd.mul_en = 1'b1;
        cmd.a_sel  = A_SES;
        cmd.b_sel  = B_SKI;
        state_nxt  = ST_D_SUM;
      end
      ST_D_SUM: begin
        // hold the last product until the result register is free
        if (out_free) begin
          cmd.acc_op    = ACC_ADD;
          cmd.wr_drv    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/cascaded_pi_joint_regulator_top.sv =====
// ----------------------------------------------------------------------------
// cascaded_pi_joint_regulator_top
// Position/speed cascade of PI loops giving one drive force per tick.
// ----------------------------------------------------------------------------
// Usage: each item on in_item is one control tick (measured position and
// speed, velocity setpoint, time step). Each tick yields one item on
// out_item with the drive force and a flag set when any integral, target,
// speed goal or the drive clipped. Gains and loop_mode are written through
// cfg_we / cfg_index / cfg_wdata; the user must do so only while no tick is
// in flight, as the block itself does not enforce it.
// Sequencing: one tick at a time runs through a single shared 33x31
// multiplier with a sum register behind it. With both loop_mode bits set
// a tick integrates the setpoint, runs the outer loop, then the inner loop;
// a clear bit skips its step. The input opens in the cycle the result
// appears, so a new tick is accepted only once the last one is finished.
// Reset (rst_n low, synchronous): gains and mode take their defaults, the
// position target goes to the home value, the speed goal to 0.2 and the
// sums and last drive to zero; no result is pending.
// Backpressure: a finished result waits in the output register; a new tick
// is still accepted and runs until its own result, then holds there until
// out_item.ready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_pi_joint_regulator_top
  import cpjr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  cpjr_in_if.sink                in_item,
  cpjr_out_if.source             out_item,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0] cfg_wdata
);

  cpjr_cmd_t  cmd;
  cpjr_stat_t stat;

  cpjr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpjr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .measured_position (in_item.measured_position),
    .measured_speed    (in_item.measured_speed),
    .velocity_setpoint (in_item.velocity_setpoint),
    .time_step         (in_item.time_step),
    .cmd               (cmd),
    .stat              (stat),
    .drive_force       (out_item.drive_force),
    .saturated         (out_item.saturated)
  );

endmodule

`default_nettype wire

// ===== sv/cpjr_checker.sv =====
// ----------------------------------------------------------------------------
// cpjr_checker
// Port-level checks of the regulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cascaded_pi_joint_regulator_top_macros.svh"

module cpjr_checker
  import cpjr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_drive_force,
  input wire logic              out_saturated
);

  // A stalled result holds
  `CPJR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_drive_force) && $stable(out_saturated), "stalled result changed")

  // Reset leaves no result pending and the input open
  `CPJR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

  // An accepted item closes the input while it runs
  `CPJR_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "input open during a tick")

  // A new result only comes out of a running tick
  `CPJR_ASSERT(a_result_from_tick, $rose(out_valid) |-> $past(!in_ready), "result without a tick")

endmodule

bind cascaded_pi_joint_regulator_top cpjr_checker u_cpjr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_item.valid),
  .in_ready        (in_item.ready),
  .out_valid       (out_item.valid),
  .out_ready       (out_item.ready),
  .out_drive_force (out_item.drive_force),
  .out_saturated   (out_item.saturated)
);

`default_nettype wire
